>>> src/ray_box_slab_intersect_macros.svh
// Assertion macros shared by the checker.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define RBSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RBSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_REGS   = 6;
    localparam int PDATA_W    = (COORD_W > 32) ? 64 : 32;
    localparam int ADDR_LSB   = (COORD_W > 32) ? 3 : 2;
    localparam int PADDR_W    = ADDR_LSB + 3;
    localparam int DIVIDEND_W = COORD_W + 1 + FRAC_BITS;
    // Prep register, divider pre-check, one stage per quotient bit, ordering register.
    localparam int LANE_LAT   = COORD_W + 3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    // What one axis lane hands to the merge stage.
    typedef struct packed {
        logic   zero;     // direction component is zero
        logic   in_slab;  // origin lies within the slab
        coord_t t_near;   // smaller slab parameter
        coord_t t_far;    // larger slab parameter
    } lane_res_t;
endpackage

>>> src/rbsi_ifs.sv
`timescale 1ns / 1ps
interface rbsi_ray_if;
    import rbsi_pkg::*;
    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbsi_hit_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

>>> src/rbsi_div.sv
`timescale 1ns / 1ps
module rbsi_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [rbsi_pkg::COORD_W:0]     nmag,
    input  logic [rbsi_pkg::COORD_W-1:0]   dmag,
    input  logic                           qneg,
    output rbsi_pkg::coord_t               t
);
    import rbsi_pkg::*;

    logic [DIVIDEND_W-1:0] dividend;
    logic [FRAC_BITS:0]    div_hi;
    logic                  ovf_next;

    logic [COORD_W:0]   r_reg   [COORD_W+1];
    logic [COORD_W-1:0] lo_reg  [COORD_W+1];
    logic [COORD_W-1:0] d_reg   [COORD_W+1];
    logic [COORD_W-1:0] q_reg   [COORD_W+1];
    logic               ovf_reg [COORD_W+1];
    logic               neg_reg [COORD_W+1];

    assign dividend = {nmag, {FRAC_BITS{1'b0}}};
    assign div_hi   = dividend[DIVIDEND_W-1:COORD_W];
    // Quotient bits above the result width mean the value saturates anyway.
    assign ovf_next = (COORD_W+1)'(div_hi) >= {1'b0, dmag};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= ovf_next ? '0 : (COORD_W+1)'(div_hi);
            lo_reg[0]  <= dividend[COORD_W-1:0];
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= qneg;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 0; s < COORD_W; s++)
    begin : g_step
        logic [COORD_W:0] r_shift;
        logic             ge;
        assign r_shift = {r_reg[s][COORD_W-1:0], lo_reg[s][COORD_W-1-s]};
        assign ge      = r_shift >= {1'b0, d_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]   <= ge ? (r_shift - {1'b0, d_reg[s]}) : r_shift;
                lo_reg[s+1]  <= lo_reg[s];
                d_reg[s+1]   <= d_reg[s];
                q_reg[s+1]   <= {q_reg[s][COORD_W-2:0], ge};
                ovf_reg[s+1] <= ovf_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    logic [COORD_W-1:0] q_fin;
    logic [COORD_W-1:0] half;
    assign q_fin = q_reg[COORD_W];
    assign half  = {1'b1, {(COORD_W-1){1'b0}}};

    always_comb
    begin
        if (neg_reg[COORD_W])
        begin
            if (ovf_reg[COORD_W] || q_fin > half)
                t = coord_t'(half);
            else
                t = coord_t'(-q_fin);
        end
        else
        begin
            if (ovf_reg[COORD_W] || q_fin > half - 1'b1)
                t = coord_t'(half - 1'b1);
            else
                t = coord_t'(q_fin);
        end
    end
endmodule

>>> src/rbsi_lane.sv
`timescale 1ns / 1ps
module rbsi_lane (
    input  logic                 clk,
    input  logic                 en,
    input  rbsi_pkg::coord_t     bmin,
    input  rbsi_pkg::coord_t     bmax,
    input  rbsi_pkg::coord_t     origin,
    input  rbsi_pkg::coord_t     dir,
    output rbsi_pkg::lane_res_t  res
);
    import rbsi_pkg::*;

    logic signed [COORD_W:0] diff_min;
    logic signed [COORD_W:0] diff_max;
    logic                    dneg;

    logic [COORD_W:0]   nmag0_reg;
    logic [COORD_W:0]   nmag1_reg;
    logic [COORD_W-1:0] dmag_reg;
    logic               qneg0_reg;
    logic               qneg1_reg;

    logic zero_reg    [LANE_LAT-1];
    logic in_slab_reg [LANE_LAT-1];

    coord_t    t0;
    coord_t    t1;
    lane_res_t res_reg;

    assign diff_min = (COORD_W+1)'(bmin) - (COORD_W+1)'(origin);
    assign diff_max = (COORD_W+1)'(bmax) - (COORD_W+1)'(origin);
    assign dneg     = dir[COORD_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag0_reg      <= diff_min[COORD_W] ? -diff_min : diff_min;
            nmag1_reg      <= diff_max[COORD_W] ? -diff_max : diff_max;
            dmag_reg       <= dneg ? -dir : dir;
            qneg0_reg      <= diff_min[COORD_W] ^ dneg;
            qneg1_reg      <= diff_max[COORD_W] ^ dneg;
            zero_reg[0]    <= (dir == '0);
            in_slab_reg[0] <= (origin >= bmin) && (origin <= bmax);
        end
    end

    for (genvar k = 1; k < LANE_LAT - 1; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k]    <= zero_reg[k-1];
                in_slab_reg[k] <= in_slab_reg[k-1];
            end
        end
    end

    rbsi_div u_div0 (
        .clk  (clk),
        .en   (en),
        .nmag (nmag0_reg),
        .dmag (dmag_reg),
        .qneg (qneg0_reg),
        .t    (t0)
    );

    rbsi_div u_div1 (
        .clk  (clk),
        .en   (en),
        .nmag (nmag1_reg),
        .dmag (dmag_reg),
        .qneg (qneg1_reg),
        .t    (t1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.zero    <= zero_reg[LANE_LAT-2];
            res_reg.in_slab <= in_slab_reg[LANE_LAT-2];
            res_reg.t_near  <= (t0 > t1) ? t1 : t0;
            res_reg.t_far   <= (t0 > t1) ? t0 : t1;
        end
    end

    assign res = res_reg;
endmodule

>>> src/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge (
    input  logic                 clk,
    input  logic                 en,
    input  rbsi_pkg::lane_res_t  lanes [rbsi_pkg::NUM_AXES],
    output logic                 hit
);
    import rbsi_pkg::*;

    logic hit_next;
    logic hit_reg;

    // Narrow the running interval axis by axis; touching counts as overlap.
    always_comb
    begin
        coord_t lo;
        coord_t hi;
        lo       = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
        hi       = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
        hit_next = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (lanes[a].zero)
            begin
                if (!lanes[a].in_slab)
                    hit_next = 1'b0;
            end
            else
            begin
                if (lo > lanes[a].t_far || lanes[a].t_near > hi)
                    hit_next = 1'b0;
                if (lanes[a].t_near > lo)
                    lo = lanes[a].t_near;
                if (lanes[a].t_far < hi)
                    hi = lanes[a].t_far;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

    assign hit = hit_reg;
endmodule

>>> src/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// Ray versus axis-aligned box test by the slab method. One ray item is taken per clock unless the
// pipeline is stalled, and one hit item comes out for each, in order. The per-axis dividers
// retire one quotient bit per pipeline stage. Three lanes, one per axis, work on x, y and z side by
// side and a merge stage combines their slab intervals. The box comes from six APB registers
// that must only be written while no item is in flight. The whole pipeline stalls together
// when the result register holds an item that the downstream side has not taken.
module ray_box_slab_intersect (
    input  logic                          clk,
    input  logic                          rst_n,
    rbsi_ray_if.sink                      ray,
    rbsi_hit_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbsi_pkg::PADDR_W-1:0]  paddr,
    input  logic [rbsi_pkg::PDATA_W-1:0]  pwdata,
    output logic [rbsi_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import rbsi_pkg::*;

    // Box registers, indexed by axis.
    coord_t box_min_reg [NUM_AXES];
    coord_t box_max_reg [NUM_AXES];

    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:ADDR_LSB]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_X: box_min_reg[0] <= coord_t'(pwdata[COORD_W-1:0]);
                REG_MIN_Y: box_min_reg[1] <= coord_t'(pwdata[COORD_W-1:0]);
                REG_MIN_Z: box_min_reg[2] <= coord_t'(pwdata[COORD_W-1:0]);
                REG_MAX_X: box_max_reg[0] <= coord_t'(pwdata[COORD_W-1:0]);
                REG_MAX_Y: box_max_reg[1] <= coord_t'(pwdata[COORD_W-1:0]);
                REG_MAX_Z: box_max_reg[2] <= coord_t'(pwdata[COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_X: prdata = PDATA_W'(box_min_reg[0]);
            REG_MIN_Y: prdata = PDATA_W'(box_min_reg[1]);
            REG_MIN_Z: prdata = PDATA_W'(box_min_reg[2]);
            REG_MAX_X: prdata = PDATA_W'(box_max_reg[0]);
            REG_MAX_Y: prdata = PDATA_W'(box_max_reg[1]);
            REG_MAX_Z: prdata = PDATA_W'(box_max_reg[2]);
            default:   prdata = '0;
        endcase
    end

    // The pipeline moves whenever the output register is empty or being drained.
    logic en;
    logic out_valid_reg;
    logic vld_reg [LANE_LAT];

    assign en        = !out_valid_reg || res.ready;
    assign ray.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_LAT; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= ray.valid;
            for (int k = 1; k < LANE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    coord_t    origin [NUM_AXES];
    coord_t    dir    [NUM_AXES];
    lane_res_t lanes  [NUM_AXES];

    assign origin[0] = ray.origin_x;
    assign origin[1] = ray.origin_y;
    assign origin[2] = ray.origin_z;
    assign dir[0]    = ray.dir_x;
    assign dir[1]    = ray.dir_y;
    assign dir[2]    = ray.dir_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        rbsi_lane u_lane (
            .clk    (clk),
            .en     (en),
            .bmin   (box_min_reg[a]),
            .bmax   (box_max_reg[a]),
            .origin (origin[a]),
            .dir    (dir[a]),
            .res    (lanes[a])
        );
    end

    rbsi_merge u_merge (
        .clk   (clk),
        .en    (en),
        .lanes (lanes),
        .hit   (res.hit)
    );

    assign res.valid = out_valid_reg;
endmodule

>>> src/rbsi_checker.sv
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_macros.svh"
module rbsi_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_hit,
    input logic pready
);
    `RBSI_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
    `RBSI_ASSERT(a_out_hold,
                 out_valid && !out_ready |=> out_valid && $stable(out_hit),
                 "result item changed while stalled")
    `RBSI_ASSERT(a_stall_input, out_valid && !out_ready |-> !in_ready,
                 "input taken while pipeline stalled")
    `RBSI_ASSERT(a_drain_ready, !out_valid |-> in_ready, "input refused with empty output")
endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_hit   (res.hit),
    .pready    (pready)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

import rbsi_pkg::*;

// Keeps the box as software last wrote it and the hit flags still owed by the block.
class hit_scoreboard;
    coord_t box_lo[NUM_AXES];
    coord_t box_hi[NUM_AXES];
    bit     pending_hits[$];
    int     errors;

    function new();
        foreach (box_lo[a])
        begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        errors = 0;
    endfunction

    // Truncated, saturated (bound - origin) / dir with 16 fraction bits; dir is nonzero.
    function automatic longint slab_param(coord_t bound, coord_t org, coord_t dir);
        longint      diff;
        longint      dsig;
        logic [63:0] nmag;
        logic [63:0] dmag;
        logic [63:0] quot;
        bit          neg;
        diff = longint'(bound) - longint'(org);
        dsig = longint'(dir);
        neg  = (diff < 0) != (dsig < 0);
        nmag = (diff < 0) ? -diff : diff;
        dmag = (dsig < 0) ? -dsig : dsig;
        quot = (nmag << FRAC_BITS) / dmag;
        if (neg)
            return (quot > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(quot);
        return (quot > 64'h7fff_ffff) ? 64'sh7fff_ffff : longint'(quot);
    endfunction

    function automatic bit ray_hits(coord_t org[NUM_AXES], coord_t dir[NUM_AXES]);
        longint t_lo;
        longint t_hi;
        longint t0;
        longint t1;
        longint tmp;
        bit     result;
        t_lo   = -64'sh7fff_ffff_ffff_ffff - 1;
        t_hi   = 64'sh7fff_ffff_ffff_ffff;
        result = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (dir[a] == 0)
            begin
                if (org[a] < box_lo[a] || org[a] > box_hi[a])
                    result = 1'b0;
                continue;
            end
            t0 = slab_param(box_lo[a], org[a], dir[a]);
            t1 = slab_param(box_hi[a], org[a], dir[a]);
            if (t0 > t1)
            begin
                tmp = t0;
                t0  = t1;
                t1  = tmp;
            end
            if (t_lo > t1 || t0 > t_hi)
                result = 1'b0;
            if (t0 > t_lo)
                t_lo = t0;
            if (t1 < t_hi)
                t_hi = t1;
        end
        return result;
    endfunction

    function void note_ray(coord_t org[NUM_AXES], coord_t dir[NUM_AXES]);
        pending_hits.push_back(ray_hits(org, dir));
    endfunction

    function void check_hit(logic hit);
        bit want;
        if (pending_hits.size() == 0)
        begin
            $error("hit item %0d arrived with no ray outstanding", hit);
            errors++;
            return;
        end
        want = pending_hits.pop_front();
        if (hit !== want)
        begin
            $error("field hit: expected %0d, actual %0d", want, hit);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int PERIOD_NS  = 12;
    // Generous bound on cycles with no accepted ray, hit or register write.
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 300;
    // One unit in Q16.16.
    localparam int ONE        = 1 << FRAC_BITS;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    rbsi_ray_if ray_ch ();
    rbsi_hit_if hit_ch ();

    ray_box_slab_intersect uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray     (ray_ch.sink),
        .res     (hit_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hit_scoreboard sb = new();

    // The receiver reads the first two to decide how long it holds off before each hit item.
    int  recv_max_gap = 6;
    bit  hold_request = 0;
    int  idle_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD_NS / 2) clk = ~clk;
    end

    // All accepted traffic is observed here, at the rising edge. A ray is predicted with the
    // box copy that is current when it is taken, which is safe because the box only changes
    // while the pipeline is empty.
    always @(posedge clk)
    begin
        coord_t org[NUM_AXES];
        coord_t dir[NUM_AXES];
        if (rst_n)
        begin
            if (ray_ch.valid && ray_ch.ready)
            begin
                org = '{ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z};
                dir = '{ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z};
                sb.note_ray(org, dir);
            end
            if (hit_ch.valid && hit_ch.ready)
                sb.check_hit(hit_ch.hit);
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver side. Each hit item is preceded by a random hold-off; when the main sequence
    // asks for pressure, one long hold-off lets the pipeline fill and stall the ray input.
    initial
    begin
        int gap;
        hit_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, recv_max_gap);
            if (hold_request)
            begin
                gap          = LONG_HOLD;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                hit_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            hit_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!hit_ch.valid);
        end
    end

    // One APB write: setup phase, then access phase; pready is always high.
    task automatic write_reg(reg_idx_t idx, coord_t value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(int'(idx) << ADDR_LSB);
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx <= REG_MIN_Z)
            sb.box_lo[int'(idx)] = value;
        else
            sb.box_hi[int'(idx) - int'(REG_MAX_X)] = value;
    endtask

    // Writes the whole box: lower corner first, then upper corner.
    task automatic load_box(coord_t lo[NUM_AXES], coord_t hi[NUM_AXES]);
        write_reg(REG_MIN_X, lo[0]);
        write_reg(REG_MIN_Y, lo[1]);
        write_reg(REG_MIN_Z, lo[2]);
        write_reg(REG_MAX_X, hi[0]);
        write_reg(REG_MAX_Y, hi[1]);
        write_reg(REG_MAX_Z, hi[2]);
    endtask

    // Offers one ray after a random gap; the valid stays high across back-to-back items.
    task automatic send_ray(coord_t org[NUM_AXES], coord_t dir[NUM_AXES], int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            ray_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ray_ch.origin_x = org[0];
        ray_ch.origin_y = org[1];
        ray_ch.origin_z = org[2];
        ray_ch.dir_x    = dir[0];
        ray_ch.dir_y    = dir[1];
        ray_ch.dir_z    = dir[2];
        ray_ch.valid    = 1'b1;
        do
            @(posedge clk);
        while (!ray_ch.ready);
        @(negedge clk);
    endtask

    // Lets the pipeline empty so the box may be rewritten safely.
    task automatic drain();
        ray_ch.valid = 1'b0;
        while (sb.pending_hits.size() != 0)
            @(negedge clk);
        repeat (LANE_LAT + 8) @(negedge clk);
    endtask

    // Coordinates are mostly near the box so slabs actually overlap, with a share of full-range
    // values, extremes and zeros to reach the saturation and zero-direction cases.
    function automatic coord_t rand_coord(coord_t lo, coord_t hi);
        longint span;
        case ($urandom_range(0, 9))
            0, 1:    return coord_t'($urandom());
            2:       return '0;
            3:       return ($urandom_range(0, 1)) ? coord_t'(32'h7fff_ffff)
                                                     : coord_t'(32'h8000_0000);
            4:       return coord_t'($signed($urandom_range(0, 64)) - 32);
            default:
            begin
                span = (longint'(hi) > longint'(lo)) ? longint'(hi) - longint'(lo) : 64'd4;
                if (span > 64'h3fff_ffff)
                    span = 64'h3fff_ffff;
                return coord_t'(longint'(lo) - span / 2 + longint'($urandom_range(0,
                               int'(span) * 2 > 0 ? int'(span) * 2 : 1)));
            end
        endcase
    endfunction

    task automatic random_rays(int count, int max_gap);
        coord_t org[NUM_AXES];
        coord_t dir[NUM_AXES];
        repeat (count)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                org[a] = rand_coord(sb.box_lo[a], sb.box_hi[a]);
                // Directions are small or full range; zero shows up through rand_coord.
                dir[a] = ($urandom_range(0, 2) == 0) ? coord_t'($urandom())
                                                      : rand_coord(-ONE * 4, ONE * 4);
            end
            send_ray(org, dir, max_gap);
        end
    endtask

    initial
    begin
        coord_t lo[NUM_AXES];
        coord_t hi[NUM_AXES];
        coord_t org[NUM_AXES];
        coord_t dir[NUM_AXES];
        coord_t dmax;
        coord_t dmin;

        dmax = 32'h7fff_ffff;
        dmin = 32'h8000_0000;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        ray_ch.valid    = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x    = '0;
        ray_ch.dir_y    = '0;
        ray_ch.dir_z    = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The reset box is a single point at the origin: a ray from there with no direction
        // is inside, and any ray along an axis through the point touches it.
        send_ray('{0, 0, 0}, '{0, 0, 0}, 0);
        send_ray('{ONE, 0, 0}, '{0, 0, 0}, 0);
        send_ray('{-ONE, 0, 0}, '{ONE, 0, 0}, 0);
        send_ray('{ONE, ONE, 0}, '{ONE, ONE, 0}, 0);
        drain();

        // A plain cube of side 20 centered on the origin.
        lo = '{-10 * ONE, -10 * ONE, -10 * ONE};
        hi = '{10 * ONE, 10 * ONE, 10 * ONE};
        load_box(lo, hi);
        // Straight through along each axis, from the negative side for x and z and the positive side for y.
        send_ray('{-20 * ONE, 0, 0}, '{ONE, 0, 0}, 0);
        send_ray('{0, 20 * ONE, 0}, '{0, -ONE, 0}, 0);
        send_ray('{0, 0, -20 * ONE}, '{0, 0, ONE}, 0);
        // Box behind the origin still hits.
        send_ray('{20 * ONE, 0, 0}, '{ONE, 0, 0}, 0);
        // Zero direction with the origin outside that slab misses.
        send_ray('{-20 * ONE, 11 * ONE, 0}, '{ONE, 0, 0}, 0);
        // Grazing the face exactly: touching counts.
        send_ray('{-20 * ONE, 10 * ONE, 0}, '{ONE, 0, 0}, 0);
        // Diagonal that passes the corner region and one that misses it.
        send_ray('{-20 * ONE, -20 * ONE, 0}, '{ONE, ONE, 0}, 0);
        send_ray('{-20 * ONE, 5 * ONE, 0}, '{ONE, ONE, 0}, 0);
        // Extreme directions and origins drive the quotient into saturation.
        send_ray('{dmin, dmax, dmin}, '{dmax, dmin, 1}, 0);
        send_ray('{dmax, dmin, dmax}, '{1, -1, dmin}, 0);
        send_ray('{0, 0, 0}, '{1, 1, 1}, 0);
        send_ray('{dmax, dmax, dmax}, '{dmin, dmin, dmin}, 0);
        random_rays(150, 6);
        drain();

        // Largest possible box: differences and quotients reach their widest.
        lo = '{dmin, dmin, dmin};
        hi = '{dmax, dmax, dmax};
        load_box(lo, hi);
        send_ray('{dmin, dmax, 0}, '{1, -1, 0}, 0);
        send_ray('{dmax, dmin, dmin}, '{dmin, dmax, 0}, 0);
        random_rays(150, 6);
        drain();

        // Inverted box: nonzero directions just order the parameters, zero ones always miss.
        lo = '{10 * ONE, 10 * ONE, 10 * ONE};
        hi = '{-10 * ONE, -10 * ONE, -10 * ONE};
        load_box(lo, hi);
        send_ray('{0, 0, 0}, '{ONE, ONE, ONE}, 0);
        send_ray('{0, 0, 0}, '{ONE, ONE, 0}, 0);
        random_rays(150, 6);
        drain();

        // Thin slab box with no idling on either side, then with the receiver held off
        // for a long stretch while rays keep coming.
        lo = '{-ONE, -100 * ONE, -ONE / 2};
        hi = '{ONE, 100 * ONE, ONE / 2};
        load_box(lo, hi);
        recv_max_gap = 0;
        random_rays(150, 0);
        hold_request = 1;
        random_rays(150, 2);
        recv_max_gap = 6;
        drain();

        // Random boxes, each written only once the pipeline is empty.
        repeat (4)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                lo[a] = coord_t'($signed($urandom_range(0, 2000)) - 1000) * (ONE / 8);
                hi[a] = lo[a] + coord_t'($urandom_range(0, 400)) * (ONE / 8);
            end
            load_box(lo, hi);
            random_rays(60, 6);
            drain();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/rbsi_pkg.sv
src/rbsi_ifs.sv
src/rbsi_div.sv
src/rbsi_lane.sv
src/rbsi_merge.sv
src/ray_box_slab_intersect.sv
src/rbsi_checker.sv
sim/tb.sv
